// ===== rtl/core/tls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tls_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int PIX_W      = 16;
   localparam int TERM_W     = PIX_W + 1;
   localparam int LAP_W      = 19;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 12;
   localparam int RSP_DATA_W = 48;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_THRESHOLD = 2'd2;

   localparam int RES_PER_PIXEL = 3;

   typedef struct packed {
      logic signed [TERM_W-1:0] t0;
      logic signed [TERM_W-1:0] t1;
      logic signed [TERM_W-1:0] t2;
      logic signed [TERM_W-1:0] t3;
      logic [COL_W-1:0]         col;
      logic [ROW_W-1:0]         row;
   } result_type;

   typedef struct packed {
      logic [RES_PER_PIXEL-1:0]       pend;
      result_type [RES_PER_PIXEL-1:0] res;
      logic                           frame_end;
   } bundle_type;

endpackage

`default_nettype wire

// ===== rtl/core/thresholded_laplacian_stencil.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Thresholded four-neighbour Laplacian over a raster pixel stream. Each transaction on the
// req_ side carries one unsigned Q8.8 pixel; each transaction on the rsp_ side carries one
// signed Q11.8 result with its column and row. The result for pixel (x, y-1) leaves when pixel
// (x, y) arrives, so a frame's results trail its pixels by one row, and the last row also emits
// its own results. Outside the last row the block takes one pixel per clock unless the rsp_
// side stalls; each result passes through the stage-1, bundle and output registers. In the
// last row of a frame taller than one row every pixel after the first gives two results and
// the final pixel three, all through one output register, so there a pixel holds stage 1
// until the bundle register has emptied. The two row stores are single memories of MAX_WIDTH
// entries, read on accept and written as stage 1 advances; no clearing is needed after reset.
module thresholded_laplacian_stencil #(
   parameter int MAX_WIDTH  = tls_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = tls_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [tls_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [tls_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // pixel_value [15:0]
   input  wire logic [tls_pkg::PIX_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // laplacian_value [18:0], out_column [28:19], out_row [40:29], zero [47:41]
   output logic [tls_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   // frame_done [0]
   output logic                                rsp_tuser
);
   import tls_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   function automatic logic signed [TERM_W-1:0] thr_term(input logic [PIX_W-1:0] c,
                                                         input logic [PIX_W-1:0] nb,
                                                         input logic [PIX_W-1:0] thr,
                                                         input logic en);
      logic signed [TERM_W-1:0] d;
      logic [TERM_W-1:0]        mag;
      d   = $signed({1'b0, c}) - $signed({1'b0, nb});
      mag = d[TERM_W-1] ? TERM_W'(-d) : TERM_W'(d);
      return (en && (mag > {1'b0, thr})) ? d : '0;
   endfunction

   logic [FW_W-1:0]  fw_ff;
   logic [FH_W-1:0]  fh_ff;
   logic [PIX_W-1:0] thr_ff;

   logic [CW-1:0] x_ff, x_in;
   logic [RW-1:0] y_ff, y_in;
   logic [CW-1:0] lc_idx;
   logic [RW-1:0] lr_idx;
   logic [CW-1:0] xa1;
   logic          lc_now, lr_now;
   logic          in_acc;

   logic [PIX_W-1:0] up_mem_ff  [MAX_WIDTH];
   logic [PIX_W-1:0] old_mem_ff [MAX_WIDTH];
   logic [PIX_W-1:0] up0_rd_ff, up1_rd_ff, old0_rd_ff;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]    s1_x_ff;
   logic [RW-1:0]    s1_y_ff;
   logic             s1_lc_ff, s1_lr_ff, s1_xnz_ff, s1_x1_ff, s1_ynz_ff, s1_y1_ff;
   logic             fwd_x_ff, fwd_x1_ff;
   logic [PIX_W-1:0] fwd_up_ff, fwd_old_ff;

   logic [PIX_W-1:0] upleft_ff;
   logic [PIX_W-1:0] recent0_ff, recent1_ff;

   logic [PIX_W-1:0] up_x, up_x1, old_x;
   logic             s1_adv;
   logic             bun_ready;
   bundle_type       bun;
   logic [CW-1:0]    s1_xm1;
   logic [RW-1:0]    s1_ym1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= FW_W'(1024);
         fh_ff  <= FH_W'(1024);
         thr_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:    fw_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT:   fh_ff  <= csr_wdata[FH_W-1:0];
            CSR_DIFF_THRESHOLD: thr_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (fw_ff == '0) begin
         lc_idx = '0;
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         lc_idx = CW'(MAX_WIDTH - 1);
      end else begin
         lc_idx = CW'(fw_ff - 1'b1);
      end
      if (fh_ff == '0) begin
         lr_idx = '0;
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         lr_idx = RW'(MAX_HEIGHT - 1);
      end else begin
         lr_idx = RW'(fh_ff - 1'b1);
      end
      lc_now = (x_ff >= lc_idx);
      lr_now = (y_ff >= lr_idx);
      xa1    = x_ff + 1'b1;
   end

   assign s1_adv      = s1_valid_ff && bun_ready;
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign in_acc      = req_tvalid && req_tready;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (in_acc) begin
         if (lc_now) begin
            x_in = '0;
            y_in = lr_now ? '0 : y_ff + 1'b1;
         end else begin
            x_in = x_ff + 1'b1;
         end
      end
      if (in_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         s1_valid_ff <= 1'b0;
         upleft_ff   <= '0;
         recent0_ff  <= '0;
         recent1_ff  <= '0;
      end else begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            upleft_ff  <= up_x;
            recent0_ff <= s1_pix_ff;
            recent1_ff <= recent0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         up0_rd_ff  <= up_mem_ff[x_ff];
         up1_rd_ff  <= up_mem_ff[xa1];
         old0_rd_ff <= old_mem_ff[x_ff];
      end
      if (s1_adv) begin
         up_mem_ff[s1_x_ff]  <= s1_pix_ff;
         old_mem_ff[s1_x_ff] <= up_x;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         s1_pix_ff  <= req_tdata;
         s1_x_ff    <= x_ff;
         s1_y_ff    <= y_ff;
         s1_lc_ff   <= lc_now;
         s1_lr_ff   <= lr_now;
         s1_xnz_ff  <= (x_ff != '0);
         s1_x1_ff   <= (x_ff > CW'(1));
         s1_ynz_ff  <= (y_ff != '0);
         s1_y1_ff   <= (y_ff > RW'(1));
         fwd_x_ff   <= s1_adv && (s1_x_ff == x_ff);
         fwd_x1_ff  <= s1_adv && (s1_x_ff == xa1);
         fwd_up_ff  <= s1_pix_ff;
         fwd_old_ff <= up_x;
      end
   end

   always_comb begin
      up_x   = fwd_x_ff  ? fwd_up_ff  : up0_rd_ff;
      up_x1  = fwd_x1_ff ? fwd_up_ff  : up1_rd_ff;
      old_x  = fwd_x_ff  ? fwd_old_ff : old0_rd_ff;
      s1_xm1 = s1_x_ff - 1'b1;
      s1_ym1 = s1_y_ff - 1'b1;

      bun.pend[0]    = s1_ynz_ff;
      bun.res[0].t0  = thr_term(up_x, upleft_ff, thr_ff, s1_xnz_ff);
      bun.res[0].t1  = thr_term(up_x, up_x1, thr_ff, !s1_lc_ff);
      bun.res[0].t2  = thr_term(up_x, old_x, thr_ff, s1_y1_ff);
      bun.res[0].t3  = thr_term(up_x, s1_pix_ff, thr_ff, 1'b1);
      bun.res[0].col = COL_W'(s1_x_ff);
      bun.res[0].row = ROW_W'(s1_ym1);

      bun.pend[1]    = s1_lr_ff && s1_xnz_ff;
      bun.res[1].t0  = thr_term(recent0_ff, recent1_ff, thr_ff, s1_x1_ff);
      bun.res[1].t1  = thr_term(recent0_ff, s1_pix_ff, thr_ff, 1'b1);
      bun.res[1].t2  = thr_term(recent0_ff, upleft_ff, thr_ff, s1_ynz_ff);
      bun.res[1].t3  = '0;
      bun.res[1].col = COL_W'(s1_xm1);
      bun.res[1].row = ROW_W'(s1_y_ff);

      bun.pend[2]    = s1_lr_ff && s1_lc_ff;
      bun.res[2].t0  = thr_term(s1_pix_ff, recent0_ff, thr_ff, s1_xnz_ff);
      bun.res[2].t1  = thr_term(s1_pix_ff, up_x, thr_ff, s1_ynz_ff);
      bun.res[2].t2  = '0;
      bun.res[2].t3  = '0;
      bun.res[2].col = COL_W'(s1_x_ff);
      bun.res[2].row = ROW_W'(s1_y_ff);

      bun.frame_end  = s1_lr_ff && s1_lc_ff;
   end

   tls_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .bun_valid  (s1_valid_ff),
      .bun        (bun),
      .bun_ready  (bun_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/core/tls_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tls_emit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           bun_valid,
   input  wire tls_pkg::bundle_type            bun,
   output logic                                bun_ready,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // laplacian_value [18:0], out_column [28:19], out_row [40:29], zero [47:41]
   output logic [tls_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   // frame_done [0]
   output logic                                rsp_tuser
);
   import tls_pkg::*;

   logic [RES_PER_PIXEL-1:0]       pend_ff, pend_in;
   result_type [RES_PER_PIXEL-1:0] res_ff;
   logic                           fend_ff;
   logic                           vld_ff, vld_in;
   logic signed [LAP_W-1:0]        lap_ff;
   logic [COL_W-1:0]               col_ff;
   logic [ROW_W-1:0]               row_ff;
   logic                           last_ff;
   logic                           done_ff;

   logic [RES_PER_PIXEL-1:0] sel_oh;
   logic [RES_PER_PIXEL-1:0] rest;
   logic                     is_last;
   logic                     out_load;
   logic                     bun_take;
   result_type               sel_res;
   logic signed [LAP_W-1:0]  sum;

   always_comb begin
      sel_oh   = pend_ff & (~pend_ff + 1'b1);
      rest     = pend_ff & ~sel_oh;
      is_last  = (rest == '0);
      out_load = (pend_ff != '0) && (!vld_ff || rsp_tready);
      bun_ready = (pend_ff == '0) || (out_load && is_last);
      bun_take = bun_valid && bun_ready;
      if (pend_ff[0]) begin
         sel_res = res_ff[0];
      end else if (pend_ff[1]) begin
         sel_res = res_ff[1];
      end else begin
         sel_res = res_ff[2];
      end
      sum = LAP_W'(sel_res.t0) + LAP_W'(sel_res.t1) + LAP_W'(sel_res.t2)
            + LAP_W'(sel_res.t3);
      if (bun_take) begin
         pend_in = bun.pend;
      end else if (out_load) begin
         pend_in = rest;
      end else begin
         pend_in = pend_ff;
      end
      if (out_load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bun_take) begin
         res_ff  <= bun.res;
         fend_ff <= bun.frame_end;
      end
      if (out_load) begin
         lap_ff  <= sum;
         col_ff  <= sel_res.col;
         row_ff  <= sel_res.row;
         last_ff <= is_last;
         done_ff <= is_last && fend_ff;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {(RSP_DATA_W - LAP_W - COL_W - ROW_W)'(0), row_ff, col_ff, lap_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

`default_nettype wire

// ===== tb/thresholded_laplacian_stencil_tb.sv =====
`timescale 1ns / 1ps

module thresholded_laplacian_stencil_tb;
   import tls_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int MAX_W       = DEF_MAX_WIDTH;
   localparam int MAX_H       = DEF_MAX_HEIGHT;
   localparam int PIX_MAX     = 65535;
   localparam int SETTLE      = 16;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 270;

   typedef enum {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_type;
   typedef enum {PIX_NOISE, PIX_NEAR, PIX_RAIL} pix_mode_type;

   typedef struct {
      logic signed [LAP_W-1:0] lap;
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic                    run_last;
      logic                    frame_done;
   } lap_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   thresholded_laplacian_stencil uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Shadow of the block's configuration and stencil state.
   int          fw_cfg  = 1024;
   int          fh_cfg  = 1024;
   int          thr_cfg = 0;
   logic [15:0] upper_row [MAX_W];
   logic [15:0] older_row [MAX_W];
   int          col_cnt = 0;
   int          row_cnt = 0;
   logic [15:0] recent0 = '0;
   logic [15:0] recent1 = '0;

   lap_result_type lap_results_q[$];
   int          errors     = 0;
   int          burst_left = 0;

   initial begin
      foreach (upper_row[i]) begin
         upper_row[i] = '0;
         older_row[i] = '0;
      end
   end

   function automatic int eff_width();
      return (fw_cfg < 1) ? 1 : (fw_cfg > MAX_W) ? MAX_W : fw_cfg;
   endfunction

   function automatic int eff_height();
      return (fh_cfg < 1) ? 1 : (fh_cfg > MAX_H) ? MAX_H : fh_cfg;
   endfunction

   function automatic int thr_diff(input int c, input int nb);
      int d;
      d = c - nb;
      return (((d < 0) ? -d : d) > thr_cfg) ? d : 0;
   endfunction

   function automatic lap_result_type make_result(input int s, input int col, input int row);
      lap_result_type r;
      r.lap        = s[LAP_W-1:0];
      r.col        = col[COL_W-1:0];
      r.row        = row[ROW_W-1:0];
      r.run_last   = 1'b0;
      r.frame_done = 1'b0;
      return r;
   endfunction

   task automatic compute_stencil(input logic [15:0] pix);
      int             w, h, x, y, p, c, s;
      bit             last_col, last_row;
      lap_result_type batch[$];
      w = eff_width();
      h = eff_height();
      x = col_cnt;
      y = row_cnt;
      p = int'(pix);
      last_col = (x >= w - 1);
      last_row = (y >= h - 1);
      if (y > 0) begin
         c = int'(upper_row[x]);
         s = 0;
         if (x > 0) s += thr_diff(c, int'(older_row[x-1]));
         if (!last_col) s += thr_diff(c, int'(upper_row[x+1]));
         if (y > 1) s += thr_diff(c, int'(older_row[x]));
         s += thr_diff(c, p);
         batch.push_back(make_result(s, x, y - 1));
      end
      older_row[x] = upper_row[x];
      upper_row[x] = pix;
      if (last_row) begin
         if (x > 0) begin
            c = int'(recent0);
            s = 0;
            if (x > 1) s += thr_diff(c, int'(recent1));
            s += thr_diff(c, p);
            if (y > 0) s += thr_diff(c, int'(older_row[x-1]));
            batch.push_back(make_result(s, x - 1, y));
         end
         if (last_col) begin
            s = 0;
            if (x > 0) s += thr_diff(p, int'(recent0));
            if (y > 0) s += thr_diff(p, int'(older_row[x]));
            batch.push_back(make_result(s, x, y));
         end
      end
      recent1 = recent0;
      recent0 = pix;
      if (batch.size() > 0) begin
         batch[batch.size()-1].run_last = 1'b1;
         if (last_col && last_row) batch[batch.size()-1].frame_done = 1'b1;
      end
      foreach (batch[i]) lap_results_q.push_back(batch[i]);
      if (last_col) begin
         col_cnt = 0;
         row_cnt = last_row ? 0 : y + 1;
      end else begin
         col_cnt = x + 1;
      end
   endtask

   task automatic report_mismatch(input string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Result checker: every rsp transaction is compared with the oldest prediction.
   always @(posedge clock) begin
      lap_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lap_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, tdata %h", rsp_tdata));
         end else begin
            e = lap_results_q.pop_front();
            if (rsp_tdata[18:0] !== e.lap)
               report_mismatch($sformatf("laplacian_value at (%0d,%0d): exp %0d got %0d",
                  e.col, e.row, e.lap, $signed(rsp_tdata[18:0])));
            if (rsp_tdata[28:19] !== e.col)
               report_mismatch($sformatf("out_column: exp %0d got %0d",
                  e.col, rsp_tdata[28:19]));
            if (rsp_tdata[40:29] !== e.row)
               report_mismatch($sformatf("out_row: exp %0d got %0d", e.row, rsp_tdata[40:29]));
            if (rsp_tdata[47:41] !== '0)
               report_mismatch($sformatf("tdata padding not zero: %h", rsp_tdata[47:41]));
            if (rsp_tlast !== e.run_last)
               report_mismatch($sformatf("run_last at (%0d,%0d): exp %0b got %0b",
                  e.col, e.row, e.run_last, rsp_tlast));
            if (rsp_tuser !== e.frame_done)
               report_mismatch($sformatf("frame_done at (%0d,%0d): exp %0b got %0b",
                  e.col, e.row, e.frame_done, rsp_tuser));
         end
      end
   end

   // Result-side backpressure that switches at random between open, coin-toss, pattern and sparse modes.
   rx_mode_type rx_mode    = RX_OPEN;
   int          rx_left    = 0;
   logic [7:0]  rx_pattern = 8'h01;

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode    = rx_mode_type'($urandom_range(0, 3));
         rx_left    = $urandom_range(16, 160);
         rx_pattern = 8'($urandom()) | 8'h01;
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN: begin
            rsp_tready <= 1'b1;
         end
         RX_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         RX_PATTERN: begin
            rsp_tready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val,
                            input bit close);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:    fw_cfg  = int'(val & 16'h07FF);
         CSR_FRAME_HEIGHT:   fh_cfg  = int'(val & 16'h1FFF);
         CSR_DIFF_THRESHOLD: thr_cfg = int'(val);
         default: ;
      endcase
      if (close) csr_we <= 1'b0;
   endtask

   task automatic set_frame(input logic [15:0] w, input logic [15:0] h, input logic [15:0] thr);
      write_csr(CSR_FRAME_WIDTH, w, 1'b0);
      write_csr(CSR_FRAME_HEIGHT, h, 1'b0);
      write_csr(CSR_DIFF_THRESHOLD, thr, 1'b1);
   endtask

   task automatic send_pixel(input logic [15:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            5:       gap = $urandom_range(8, 24);
            default: gap = $urandom_range(1, 4);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      compute_stencil(pix);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (lap_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [15:0] gen_pixel(input pix_mode_type mode, input int base);
      int v, span;
      span = 2 * thr_cfg + 8;
      case (mode)
         PIX_NOISE: v = $urandom_range(0, PIX_MAX);
         PIX_NEAR:  v = base + int'($urandom_range(0, span)) - span / 2;
         default:   v = $urandom_range(0, 1) ? PIX_MAX : 0;
      endcase
      if (v < 0) v = 0;
      if (v > PIX_MAX) v = PIX_MAX;
      return v[15:0];
   endfunction

   task automatic send_frame(input pix_mode_type mode, output int count);
      int base;
      base  = $urandom_range(0, PIX_MAX);
      count = eff_width() * eff_height();
      repeat (count) send_pixel(gen_pixel(mode, base));
   endtask

   // Threshold left at its reset value; largest and smallest possible sums.
   task automatic test_reset_threshold();
      write_csr(CSR_UNUSED, 16'hFFFF, 1'b0);
      write_csr(CSR_FRAME_WIDTH, 16'd3, 1'b0);
      write_csr(CSR_FRAME_HEIGHT, 16'd3, 1'b1);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'hFFFF : 16'h0000);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'h0000 : 16'hFFFF);
      wait_idle();
   endtask

   // A difference equal to the threshold is dropped, one above it is kept.
   task automatic test_threshold_edges();
      set_frame(16'd2, 16'd2, 16'd100);
      send_pixel(16'd0);
      send_pixel(16'd100);
      send_pixel(16'd101);
      send_pixel(16'd0);
      wait_idle();
      set_frame(16'd4, 16'd1, 16'hFFFF);
      send_pixel(16'd0);
      send_pixel(16'hFFFF);
      send_pixel(16'd0);
      send_pixel(16'hFFFF);
      wait_idle();
      set_frame(16'd0, 16'd0, 16'd0);
      send_pixel(16'h1234);
      wait_idle();
   endtask

   // Sizes of zero, one-row and one-column frames, and unused upper bits in the size writes.
   task automatic test_size_extremes();
      int n;
      set_frame(16'd24, 16'h0000, 16'($urandom_range(0, 300)));
      send_frame(PIX_NEAR, n);
      wait_idle();
      set_frame(16'd7, 16'd3, 16'($urandom_range(0, PIX_MAX)));
      send_frame(PIX_NOISE, n);
      wait_idle();
      set_frame(16'h0000, 16'd24, 16'($urandom_range(0, 300)));
      send_frame(PIX_NEAR, n);
      wait_idle();
      set_frame(16'hF803, 16'hE002, 16'd0);
      send_frame(PIX_RAIL, n);
      wait_idle();
   endtask

   // Many small frames; some reuse the previous settings and follow back to back.
   task automatic test_random_frames();
      int           random_items, n;
      bit           first;
      pix_mode_type mode;
      logic [15:0]  thr;
      random_items = 0;
      first = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         if (first || $urandom_range(0, 2) != 0) begin
            wait_idle();
            case ($urandom_range(0, 4))
               0:       thr = 16'd0;
               1:       thr = 16'($urandom_range(0, PIX_MAX));
               2:       thr = 16'hFFFF;
               default: thr = 16'($urandom_range(0, 600));
            endcase
            set_frame(16'($urandom_range(0, 10)), 16'($urandom_range(0, 5)), thr);
            first = 1'b0;
         end
         case ($urandom_range(0, 3))
            0:       mode = PIX_NOISE;
            1:       mode = PIX_RAIL;
            default: mode = PIX_NEAR;
         endcase
         send_frame(mode, n);
         random_items += n;
      end
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_threshold();
      test_threshold_edges();
      test_size_extremes();
      test_random_frames();
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tls_pkg.sv
rtl/core/tls_emit.sv
rtl/core/thresholded_laplacian_stencil.sv
tb/thresholded_laplacian_stencil_tb.sv
